// ===== rtl/core/pcx_pkg.sv =====
`default_nettype none

package pcx_pkg;

    localparam int GENE_W         = 4;
    localparam int GENE_SPAN      = 16;
    localparam int TOUR_W         = 5;
    localparam int MAX_CITIES_DEF = 16;
    localparam logic [TOUR_W-1:0] TOUR_RESET = 5'd16;
    localparam int MIN_TOUR       = 2;

    typedef enum logic [4:0] {
        S_LOAD  = 5'b00001,
        S_BUILD = 5'b00010,
        S_WPOS  = 5'b00100,
        S_WDEC  = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/core/pcx_ram.sv =====
`default_nettype none

module pcx_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic                                  i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds until the next read
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/permutation_cycle_crossover_core.sv =====
// Operation: tour_length (n) items load, one item per cycle; after the last item the
// gene-position table is built, then the cycle walk runs (ram read, then position
// read and decision) and the results are emitted.
// Throughput: n results on consecutive cycles; walk pace is set by the two dependent memory
// reads of each walk step; no new pair loads while busy. The receiver cannot stall results.
// Reset (synchronous, active low) returns to loading with tour_length 16; memories keep data.
`default_nettype none

module permutation_cycle_crossover_core #(
    parameter int MAX_CITIES = pcx_pkg::MAX_CITIES_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [pcx_pkg::GENE_W-1:0]   i_gene_a,
    input  wire logic [pcx_pkg::GENE_W-1:0]   i_gene_b,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [pcx_pkg::TOUR_W-1:0]   i_cfg_tour_length,
    output logic                              o_result_strobe,
    output logic      [pcx_pkg::GENE_W-1:0]   o_child_a_gene,
    output logic      [pcx_pkg::GENE_W-1:0]   o_child_b_gene,
    output logic                              o_last_gene
);

    import pcx_pkg::*;

    localparam int CAP   = (MAX_CITIES < GENE_SPAN) ? MAX_CITIES : GENE_SPAN;
    localparam int POS_W = $clog2(CAP);
    localparam int LEN_W = $clog2(CAP + 1);
    localparam int VIS_W = 2 ** POS_W;
    localparam int AB_W  = 2 * GENE_W;

    t_state             r_state, n_state;
    logic [TOUR_W-1:0]  r_tour, n_tour;
    logic [LEN_W-1:0]   r_load, n_load;
    logic [LEN_W-1:0]   r_cnt, n_cnt;
    logic [LEN_W-1:0]   r_steps, n_steps;
    logic [POS_W-1:0]   r_walk, n_walk;
    logic [GENE_W-1:0]  r_start, n_start;
    logic               r_parity, n_parity;
    logic               r_new_cycle, n_new_cycle;
    logic               r_seen_start, n_seen_start;
    logic [CAP-1:0]     r_visited, n_visited;
    logic               r_out_vld, n_out_vld;
    logic               r_out_last, n_out_last;

    logic [LEN_W-1:0]   len;
    logic [LEN_W-1:0]   len_m1;
    logic [LEN_W-1:0]   load_idx;
    logic [LEN_W-1:0]   cnt_m1;
    logic               cfg_wr;
    logic               item_acc;

    logic               ab_we, ab_re;
    logic [POS_W-1:0]   ab_waddr, ab_raddr;
    logic [AB_W-1:0]    ab_wdata, ab_q;
    logic               pos_we, pos_re;
    logic [GENE_W-1:0]  pos_waddr, pos_raddr;
    logic [POS_W-1:0]   pos_wdata, pos_q;
    logic               tk_we, tk_re;
    logic [POS_W-1:0]   tk_waddr, tk_raddr;
    logic               tk_q;

    logic [GENE_W-1:0]  q_a, q_b;
    logic [GENE_W-1:0]  start_eff;
    logic [CAP-1:0]     vis_now;
    logic [VIS_W-1:0]   vis_ext;
    logic               close_cyc;
    logic               free_found;
    logic [POS_W-1:0]   free_pos;
    logic [POS_W-1:0]   walk_next;

    // clamp the programmed length to the built range
    always_comb begin
        if (r_tour < TOUR_W'(MIN_TOUR)) begin
            len = LEN_W'(MIN_TOUR);
        end else if (r_tour > TOUR_W'(CAP)) begin
            len = LEN_W'(CAP);
        end else begin
            len = r_tour[LEN_W-1:0];
        end
    end

    assign len_m1   = len - LEN_W'(1);
    assign cnt_m1   = r_cnt - LEN_W'(1);
    assign load_idx = (r_load >= len) ? '0 : r_load;

    assign busy        = (r_state != S_LOAD);
    // hold the length write off while an item transaction is offered
    assign o_cfg_ready = (r_state == S_LOAD) && !start;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign item_acc    = start && !busy;

    assign q_a = ab_q[AB_W-1:GENE_W];
    assign q_b = ab_q[GENE_W-1:0];
    assign start_eff = r_new_cycle ? q_a : r_start;

    // walk decision: close the cycle on start gene, out of range or visited target
    always_comb begin
        vis_now    = r_visited | (CAP'(1) << r_walk);
        vis_ext    = VIS_W'(vis_now);
        close_cyc  = r_seen_start || (LEN_W'(pos_q) >= len) || vis_ext[pos_q];
        free_found = 1'b0;
        free_pos   = '0;
        for (int i = 0; i < CAP; i++) begin
            if (!free_found && (LEN_W'(i) < len) && !vis_now[i]) begin
                free_found = 1'b1;
                free_pos   = POS_W'(i);
            end
        end
        walk_next = close_cyc ? free_pos : pos_q;
    end

    // memory ports
    always_comb begin
        ab_we     = item_acc;
        ab_waddr  = load_idx[POS_W-1:0];
        ab_wdata  = {i_gene_a, i_gene_b};
        ab_re     = 1'b0;
        ab_raddr  = '0;
        pos_we    = 1'b0;
        pos_waddr = q_a;
        pos_wdata = cnt_m1[POS_W-1:0];
        pos_re    = 1'b0;
        pos_raddr = q_b;
        tk_we     = 1'b0;
        tk_waddr  = r_walk;
        tk_re     = 1'b0;
        tk_raddr  = r_cnt[POS_W-1:0];
        case (r_state)
            S_BUILD: begin
                ab_re  = 1'b1;
                pos_we = (r_cnt != '0);
                if (r_cnt != len) begin
                    ab_raddr = r_cnt[POS_W-1:0];
                end
            end
            S_WPOS: begin
                pos_re = 1'b1;
            end
            S_WDEC: begin
                tk_we    = 1'b1;
                ab_re    = 1'b1;
                ab_raddr = walk_next;
            end
            S_EMIT: begin
                ab_re    = 1'b1;
                ab_raddr = r_cnt[POS_W-1:0];
                tk_re    = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_tour       = r_tour;
        n_load       = r_load;
        n_cnt        = r_cnt;
        n_steps      = r_steps;
        n_walk       = r_walk;
        n_start      = r_start;
        n_parity     = r_parity;
        n_new_cycle  = r_new_cycle;
        n_seen_start = r_seen_start;
        n_visited    = r_visited;
        n_out_vld    = 1'b0;
        n_out_last   = 1'b0;
        case (r_state)
            S_LOAD: begin
                if (item_acc) begin
                    if (load_idx == len_m1) begin
                        n_load    = '0;
                        n_cnt     = '0;
                        n_visited = '0;
                        n_state   = S_BUILD;
                    end else begin
                        n_load = load_idx + LEN_W'(1);
                    end
                end
                if (cfg_wr) begin
                    n_tour = i_cfg_tour_length;
                    n_load = '0;
                end
            end
            S_BUILD: begin
                if (r_cnt == len) begin
                    n_walk      = '0;
                    n_parity    = 1'b0;
                    n_new_cycle = 1'b1;
                    n_steps     = '0;
                    n_state     = S_WPOS;
                end else begin
                    n_cnt = r_cnt + LEN_W'(1);
                end
            end
            S_WPOS: begin
                n_start      = start_eff;
                n_seen_start = (q_b == start_eff);
                n_state      = S_WDEC;
            end
            S_WDEC: begin
                n_visited   = vis_now;
                n_walk      = walk_next;
                n_new_cycle = close_cyc;
                if (close_cyc) begin
                    n_parity = !r_parity;
                end
                if (r_steps == len_m1) begin
                    n_cnt   = '0;
                    n_state = S_EMIT;
                end else begin
                    n_steps = r_steps + LEN_W'(1);
                    n_state = S_WPOS;
                end
            end
            S_EMIT: begin
                n_out_vld  = 1'b1;
                n_out_last = (r_cnt == len_m1);
                if (r_cnt == len_m1) begin
                    n_state = S_LOAD;
                end else begin
                    n_cnt = r_cnt + LEN_W'(1);
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_LOAD;
            r_tour       <= TOUR_RESET;
            r_load       <= '0;
            r_cnt        <= '0;
            r_steps      <= '0;
            r_walk       <= '0;
            r_start      <= '0;
            r_parity     <= 1'b0;
            r_new_cycle  <= 1'b0;
            r_seen_start <= 1'b0;
            r_visited    <= '0;
            r_out_vld    <= 1'b0;
            r_out_last   <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_tour       <= n_tour;
            r_load       <= n_load;
            r_cnt        <= n_cnt;
            r_steps      <= n_steps;
            r_walk       <= n_walk;
            r_start      <= n_start;
            r_parity     <= n_parity;
            r_new_cycle  <= n_new_cycle;
            r_seen_start <= n_seen_start;
            r_visited    <= n_visited;
            r_out_vld    <= n_out_vld;
            r_out_last   <= n_out_last;
        end
    end

    pcx_ram #(
        .WIDTH (AB_W),
        .DEPTH (CAP)
    ) u_parent_ram (
        .i_clk   (i_clk),
        .i_we    (ab_we),
        .i_waddr (ab_waddr),
        .i_wdata (ab_wdata),
        .i_re    (ab_re),
        .i_raddr (ab_raddr),
        .o_rdata (ab_q)
    );

    pcx_ram #(
        .WIDTH (POS_W),
        .DEPTH (GENE_SPAN)
    ) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (pos_we),
        .i_waddr (pos_waddr),
        .i_wdata (pos_wdata),
        .i_re    (pos_re),
        .i_raddr (pos_raddr),
        .o_rdata (pos_q)
    );

    pcx_ram #(
        .WIDTH (1),
        .DEPTH (CAP)
    ) u_take_ram (
        .i_clk   (i_clk),
        .i_we    (tk_we),
        .i_waddr (tk_waddr),
        .i_wdata (r_parity),
        .i_re    (tk_re),
        .i_raddr (tk_raddr),
        .o_rdata (tk_q)
    );

    assign o_result_strobe = r_out_vld;
    assign o_last_gene     = r_out_last;
    assign o_child_a_gene  = tk_q ? q_b : q_a;
    assign o_child_b_gene  = tk_q ? q_a : q_b;

    a_strobe_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> $past(r_state == S_EMIT))
        else $error("result strobe without a preceding emit cycle");

    a_last_has_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_gene |-> o_result_strobe)
        else $error("last mark without a result transaction");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $fell(busy)) |-> (o_result_strobe && o_last_gene))
        else $error("block went idle before the final result");

    a_walk_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WDEC) |-> (r_steps < len))
        else $error("walk ran past the tour length");

endmodule

`default_nettype wire
